>>> hw/rtl/rqrs_pkg.sv
`default_nettype none
package rqrs_pkg;

  localparam int OP_W    = 2;
  localparam int VALUE_W = 31;
  localparam int SMALL_W = 5;

  // opcodes; the remaining code is a no-op
  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_SRCH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CMP,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // latch request word, clear result
    logic push;      // enqueue the request value at the tail
    logic rd_head;   // read slot at head
    logic rd_next;   // read slot after head
    logic rotate;    // move the entry just read to the tail
    logic remove;    // drop the entry just read, report it
    logic out_load;  // move result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            hit;     // entry just read is the one to remove
    logic            last;    // one entry left in this pass
    logic            out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/rqrs_req_if.sv
`default_nettype none
interface rqrs_req_if
  import rqrs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rqrs_rsp_if.sv
`default_nettype none
interface rqrs_rsp_if
  import rqrs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [VALUE_W-1:0] data;
  logic [SMALL_W-1:0] moved;
  logic [SMALL_W-1:0] occupancy;

  modport source (output valid, output ok, output data, output moved, output occupancy,
                  input ready);
  modport sink   (input valid, input ok, input data, input moved, input occupancy,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rqrs_ctrl.sv
`default_nettype none
module rqrs_ctrl
  import rqrs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        // no request word is taken while reset is held
        req_ready = !rst;
        if (req_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_DONE;
        if (sts.op == OP_ENQ) begin
          cmd.push = !sts.full;
        end else if (sts.op inside {OP_DEQ, OP_SRCH}) begin
          if (!sts.empty) begin
            cmd.rd_head = 1'b1;
            state_next  = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (sts.hit) begin
          cmd.remove = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.rotate = 1'b1;
          if (sts.last) begin
            state_next = ST_DONE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/rqrs_dp.sv
`default_nettype none
module rqrs_dp
  import rqrs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic [OP_W-1:0]    req_opcode,
  input  wire logic [VALUE_W-1:0] req_value,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output logic                    rsp_ok,
  output logic [VALUE_W-1:0]      rsp_data,
  output logic [SMALL_W-1:0]      rsp_moved,
  output logic [SMALL_W-1:0]      rsp_occupancy
);

  localparam int IW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > SMALL_W) ? CNT_W : SMALL_W;

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [IW-1:0]      head, tail, head_inc, tail_inc;
  logic [CW-1:0]      count, left, moved;
  logic [OP_W-1:0]    op;
  logic [VALUE_W-1:0] key, rd;
  logic               res_ok;
  logic [VALUE_W-1:0] res_data;

  logic               wr_en;
  logic [VALUE_W-1:0] wr_data;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;

  assign head_inc = (head == IW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == IW'(DEPTH - 1)) ? '0 : tail + 1'b1;

  assign wr_en   = cmd.push || cmd.rotate;
  assign wr_data = cmd.rotate ? rd : key;
  assign rd_en   = cmd.rd_head || cmd.rd_next;
  assign rd_addr = cmd.rd_next ? head_inc : head;

  // slot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd <= mem[rd_addr];
    end
  end

  // ring pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.push) begin
      tail  <= tail_inc;
      count <= count + 1'b1;
    end else if (cmd.rotate) begin
      head <= head_inc;
      tail <= tail_inc;
    end else if (cmd.remove) begin
      count <= count - 1'b1;
      if (count == CW'(1)) begin
        head <= '0;
        tail <= '0;
      end else begin
        head <= head_inc;
      end
    end
  end

  // request word and per-operation result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op       <= req_opcode;
      key      <= req_value;
      left     <= count;
      moved    <= '0;
      res_ok   <= 1'b0;
      res_data <= '0;
    end else if (cmd.push) begin
      res_ok <= 1'b1;
    end else if (cmd.rotate) begin
      moved <= moved + 1'b1;
      left  <= left - 1'b1;
    end else if (cmd.remove) begin
      res_ok   <= 1'b1;
      res_data <= rd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_ok        <= res_ok;
      rsp_data      <= res_data;
      rsp_moved     <= moved[SMALL_W-1:0];
      rsp_occupancy <= count[SMALL_W-1:0];
    end
  end

  always_comb begin
    sts.op       = op;
    sts.full     = (count == CW'(DEPTH));
    sts.empty    = (count == '0);
    sts.hit      = (op == OP_DEQ) || (rd == key);
    sts.last     = (left == CW'(1));
    sts.out_free = !rsp_valid || rsp_ready;
  end

endmodule
`default_nettype wire

>>> hw/rtl/ring_queue_with_rotating_search_top.sv
`default_nettype none
// Ring queue of DEPTH identifiers with enqueue, dequeue and a rotating
// search-and-remove. Every request word gives exactly one response word:
// ok, the removed value (data), how many entries were rotated to the tail
// (moved) and the occupancy after the operation. Requests are taken one at
// a time. A request passes from the idle state through execute, then, for
// dequeue and search on a non-empty queue, through the compare state, and
// then to done, which loads its response. A dequeue examines only the head
// entry; a search walks k entries, where k is 0 on an empty queue, else 1
// up to the occupancy. The response word is valid from the cycle after
// the one that loads it, and the next request can be accepted in that same
// cycle. The walk is set by the slot memory: its single registered read port
// delivers one entry per cycle to the compare, while the write port moves a
// non-matching entry to the tail in the same cycle. A response waiting in
// the output register does not block the next request from being accepted;
// that request holds in its last cycle until the waiting word is taken.
// Slot contents are not cleared at reset; only held entries are ever read.
module ring_queue_with_rotating_search_top
  import rqrs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  rqrs_req_if.sink   req,
  rqrs_rsp_if.source rsp
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, execute, walk the ring, hand over the result
  rqrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: slot memory, pointers, counts and the output register
  rqrs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_opcode    (req.opcode),
    .req_value     (req.value),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_ok        (rsp.ok),
    .rsp_data      (rsp.data),
    .rsp_moved     (rsp.moved),
    .rsp_occupancy (rsp.occupancy)
  );

endmodule
`default_nettype wire
